### sv/b36c_pkg.sv
// shared types and constants for the binary / base-36 converter
`default_nettype none

package b36c_pkg;

    localparam int DIGIT_W         = 6;
    localparam int MAX_BITS        = 77;
    localparam int MAX_DIGITS      = 15;
    localparam int STEPS_PER_STAGE = 8;

    localparam int BITS_LOW_W    = 64;
    localparam int BITS_HIGH_W   = 13;
    localparam int DIGITS_LOW_W  = 60;
    localparam int DIGITS_HIGH_W = 30;
    localparam int STATUS_W      = 2;

    localparam logic [DIGIT_W-1:0] DIGIT_MAX      = 6'd35;
    localparam logic [DIGIT_W-1:0] DIGIT_HALF     = 6'd18;
    localparam logic [DIGIT_W-1:0] DIGIT_ADJ      = 6'd14;
    localparam logic [DIGIT_W-1:0] DIGIT_CARRY_IN = 6'd32;

    localparam logic FUNC_TO_DIGITS = 1'b0;
    localparam logic FUNC_TO_BITS   = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK,
        STATUS_BAD_DIGIT,
        STATUS_RANGE
    } b36c_status_t;

    typedef struct packed {
        logic func;
        logic bad;
        logic ovf;
    } b36c_ctl_t;

endpackage

`default_nettype wire

### sv/b36c_front.sv
// input stage: unpacks a word, masks unused positions and checks digits
`default_nettype none

module b36c_front #(
    parameter int BIT_COUNT   = 77,
    parameter int DIGIT_COUNT = 15
) (
    input  wire logic                                      aclk,
    input  wire logic                                      aresetn,
    input  wire logic                                      valid_i,
    output logic                                           ready_o,
    input  wire logic                                      func_i,
    input  wire logic [b36c_pkg::BITS_LOW_W-1:0]           bits_low_i,
    input  wire logic [b36c_pkg::BITS_HIGH_W-1:0]          bits_high_i,
    input  wire logic [b36c_pkg::DIGITS_LOW_W-1:0]         digits_low_i,
    input  wire logic [b36c_pkg::DIGITS_HIGH_W-1:0]        digits_high_i,
    output logic                                           valid_o,
    input  wire logic                                      ready_i,
    output b36c_pkg::b36c_ctl_t                            ctl_o,
    output logic [DIGIT_COUNT*b36c_pkg::DIGIT_W-1:0]       digits_o,
    output logic [BIT_COUNT-1:0]                           bits_o
);

    localparam int DW = DIGIT_COUNT * b36c_pkg::DIGIT_W;

    logic [b36c_pkg::BITS_LOW_W+b36c_pkg::BITS_HIGH_W-1:0]       full_bits;
    logic [b36c_pkg::DIGITS_LOW_W+b36c_pkg::DIGITS_HIGH_W-1:0]   full_digits;
    logic                  valid_reg;
    b36c_pkg::b36c_ctl_t   ctl_reg, ctl_next;
    logic [DW-1:0]         digits_reg, digits_next;
    logic [BIT_COUNT-1:0]  bits_reg, bits_next;

    assign full_bits   = {bits_high_i, bits_low_i};
    assign full_digits = {digits_high_i, digits_low_i};
    assign ready_o     = !valid_reg || ready_i;

    always_comb begin
        ctl_next.func = func_i;
        ctl_next.ovf  = 1'b0;
        ctl_next.bad  = 1'b0;
        if (func_i == b36c_pkg::FUNC_TO_DIGITS) begin
            bits_next   = full_bits[BIT_COUNT-1:0];
            digits_next = '0;
        end else begin
            bits_next   = '0;
            digits_next = full_digits[DW-1:0];
            for (int i = 0; i < DIGIT_COUNT; i++) begin
                if (full_digits[i*b36c_pkg::DIGIT_W +: b36c_pkg::DIGIT_W] >
                    b36c_pkg::DIGIT_MAX) begin
                    ctl_next.bad = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (ready_o) begin
            valid_reg <= valid_i;
        end
    end

    always_ff @(posedge aclk) begin
        if (valid_i && ready_o) begin
            ctl_reg    <= ctl_next;
            digits_reg <= digits_next;
            bits_reg   <= bits_next;
        end
    end

    assign valid_o  = valid_reg;
    assign ctl_o    = ctl_reg;
    assign digits_o = digits_reg;
    assign bits_o   = bits_reg;

endmodule

`default_nettype wire

### sv/b36c_stage.sv
// one pipeline stage: a group of shift-and-adjust steps of the radix conversion
`default_nettype none

module b36c_stage #(
    parameter int BIT_COUNT   = 77,
    parameter int DIGIT_COUNT = 15,
    parameter int START_STEP  = 0
) (
    input  wire logic                                      aclk,
    input  wire logic                                      aresetn,
    input  wire logic                                      valid_i,
    output logic                                           ready_o,
    input  wire b36c_pkg::b36c_ctl_t                       ctl_i,
    input  wire logic [DIGIT_COUNT*b36c_pkg::DIGIT_W-1:0]  digits_i,
    input  wire logic [BIT_COUNT-1:0]                      bits_i,
    output logic                                           valid_o,
    input  wire logic                                      ready_i,
    output b36c_pkg::b36c_ctl_t                            ctl_o,
    output logic [DIGIT_COUNT*b36c_pkg::DIGIT_W-1:0]       digits_o,
    output logic [BIT_COUNT-1:0]                           bits_o
);

    localparam int DW = DIGIT_COUNT * b36c_pkg::DIGIT_W;
    localparam int W  = b36c_pkg::DIGIT_W;

    logic                  valid_reg;
    b36c_pkg::b36c_ctl_t   ctl_reg, ctl_next;
    logic [DW-1:0]         digits_reg, digits_next;
    logic [BIT_COUNT-1:0]  bits_reg, bits_next;

    assign ready_o = !valid_reg || ready_i;

    always_comb begin
        logic [DW-1:0] dn;
        logic [W-1:0]  adj;
        logic          carry;
        ctl_next    = ctl_i;
        digits_next = digits_i;
        bits_next   = bits_i;
        dn          = '0;
        adj         = '0;
        carry       = 1'b0;
        for (int j = 0; j < b36c_pkg::STEPS_PER_STAGE; j++) begin
            if (START_STEP + j < BIT_COUNT) begin
                if (ctl_i.func == b36c_pkg::FUNC_TO_DIGITS) begin
                    // doubling: shift bits msb first into the digit vector
                    carry = bits_next[BIT_COUNT-1];
                    for (int i = 0; i < DIGIT_COUNT; i++) begin
                        adj = digits_next[i*W +: W];
                        if (adj >= b36c_pkg::DIGIT_HALF) begin
                            adj = adj + b36c_pkg::DIGIT_ADJ;
                        end
                        dn[i*W +: W] = {adj[W-2:0], carry};
                        carry = adj[W-1];
                    end
                    ctl_next.ovf = ctl_next.ovf | carry;
                    bits_next    = {bits_next[BIT_COUNT-2:0], 1'b0};
                    digits_next  = dn;
                end else begin
                    // halving: lsb of the digit vector drops into the bits
                    bits_next = {digits_next[0], bits_next[BIT_COUNT-1:1]};
                    carry = 1'b0;
                    for (int i = DIGIT_COUNT - 1; i >= 0; i--) begin
                        adj   = {carry, digits_next[i*W+1 +: W-1]};
                        carry = digits_next[i*W];
                        if (adj >= b36c_pkg::DIGIT_CARRY_IN) begin
                            adj = adj - b36c_pkg::DIGIT_ADJ;
                        end
                        dn[i*W +: W] = adj;
                    end
                    digits_next = dn;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (ready_o) begin
            valid_reg <= valid_i;
        end
    end

    always_ff @(posedge aclk) begin
        if (valid_i && ready_o) begin
            ctl_reg    <= ctl_next;
            digits_reg <= digits_next;
            bits_reg   <= bits_next;
        end
    end

    assign valid_o  = valid_reg;
    assign ctl_o    = ctl_reg;
    assign digits_o = digits_reg;
    assign bits_o   = bits_reg;

endmodule

`default_nettype wire

### sv/b36c_back.sv
// output stage: status decision, saturation and the output word register
`default_nettype none

module b36c_back #(
    parameter int BIT_COUNT   = 77,
    parameter int DIGIT_COUNT = 15
) (
    input  wire logic                                      aclk,
    input  wire logic                                      aresetn,
    input  wire logic                                      valid_i,
    output logic                                           ready_o,
    input  wire b36c_pkg::b36c_ctl_t                       ctl_i,
    input  wire logic [DIGIT_COUNT*b36c_pkg::DIGIT_W-1:0]  digits_i,
    input  wire logic [BIT_COUNT-1:0]                      bits_i,
    output logic                                           valid_o,
    input  wire logic                                      ready_i,
    output logic [b36c_pkg::BITS_LOW_W-1:0]                out_bits_low_o,
    output logic [b36c_pkg::BITS_HIGH_W-1:0]               out_bits_high_o,
    output logic [b36c_pkg::DIGITS_LOW_W-1:0]              out_digits_low_o,
    output logic [b36c_pkg::DIGITS_HIGH_W-1:0]             out_digits_high_o,
    output b36c_pkg::b36c_status_t                         status_o
);

    localparam int DW     = DIGIT_COUNT * b36c_pkg::DIGIT_W;
    localparam int W      = b36c_pkg::DIGIT_W;
    localparam int FULL_B = b36c_pkg::BITS_LOW_W + b36c_pkg::BITS_HIGH_W;
    localparam int FULL_D = b36c_pkg::DIGITS_LOW_W + b36c_pkg::DIGITS_HIGH_W;

    logic                    valid_reg;
    logic [FULL_B-1:0]       bits_reg, bits_next;
    logic [FULL_D-1:0]       digits_reg, digits_next;
    b36c_pkg::b36c_status_t  status_reg, status_next;

    assign ready_o = !valid_reg || ready_i;

    always_comb begin
        logic [DW-1:0]        dsel;
        logic [BIT_COUNT-1:0] bsel;
        dsel        = '0;
        bsel        = '0;
        status_next = b36c_pkg::STATUS_OK;
        if (ctl_i.func == b36c_pkg::FUNC_TO_DIGITS) begin
            if (ctl_i.ovf) begin
                status_next = b36c_pkg::STATUS_RANGE;
                for (int i = 0; i < DIGIT_COUNT; i++) begin
                    dsel[i*W +: W] = b36c_pkg::DIGIT_MAX;
                end
            end else begin
                dsel = digits_i;
            end
        end else begin
            if (ctl_i.bad) begin
                status_next = b36c_pkg::STATUS_BAD_DIGIT;
            end else if (digits_i != '0) begin
                status_next = b36c_pkg::STATUS_RANGE;
                bsel        = '1;
            end else begin
                bsel = bits_i;
            end
        end
        bits_next   = FULL_B'(bsel);
        digits_next = FULL_D'(dsel);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (ready_o) begin
            valid_reg <= valid_i;
        end
    end

    always_ff @(posedge aclk) begin
        if (valid_i && ready_o) begin
            bits_reg   <= bits_next;
            digits_reg <= digits_next;
            status_reg <= status_next;
        end
    end

    assign valid_o           = valid_reg;
    assign out_bits_low_o    = bits_reg[b36c_pkg::BITS_LOW_W-1:0];
    assign out_bits_high_o   = bits_reg[FULL_B-1:b36c_pkg::BITS_LOW_W];
    assign out_digits_low_o  = digits_reg[b36c_pkg::DIGITS_LOW_W-1:0];
    assign out_digits_high_o = digits_reg[FULL_D-1:b36c_pkg::DIGITS_LOW_W];
    assign status_o          = status_reg;

endmodule

`default_nettype wire

### sv/binary_base36_converter.sv
// top level of the binary / base-36 converter
`default_nettype none

// Converts a BIT_COUNT-bit binary value to DIGIT_COUNT base-36 digits
// (s_tuser low) or digits back to binary (s_tuser high), one word per cycle
// sustained while m_tready stays high. The conversion is a shift-and-adjust
// chain of BIT_COUNT steps (add 14 to each digit of 18 or more before
// doubling, subtract 14 from each digit of 32 or more after halving),
// eight steps per pipeline stage, so a word passes the front register,
// the stage registers and the output register. Every stage moves on its
// own when the one after it is empty, so bubbles close up and the input
// keeps taking words while a result waits on m_tready. Status 1 flags a
// digit above 35 (all bits zero); status 2 flags a value too large for
// the target width, saturated to all ones bits or all 35 digits.
module binary_base36_converter #(
    parameter int BIT_COUNT   = 77,
    parameter int DIGIT_COUNT = 15
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    // bits_low, bits_high, digits_low, digits_high, zero pad
    input  wire logic [167:0]  s_tdata,
    // func
    input  wire logic          s_tuser,
    output logic               m_tvalid,
    input  wire logic          m_tready,
    // out_bits_low, out_bits_high, out_digits_low, out_digits_high, status, zero pad
    output logic [175:0]       m_tdata
);

    localparam int DW     = DIGIT_COUNT * b36c_pkg::DIGIT_W;
    localparam int NSTAGE = (BIT_COUNT + b36c_pkg::STEPS_PER_STAGE - 1)
                            / b36c_pkg::STEPS_PER_STAGE;
    localparam int O_BH   = b36c_pkg::BITS_LOW_W;
    localparam int O_DL   = O_BH + b36c_pkg::BITS_HIGH_W;
    localparam int O_DH   = O_DL + b36c_pkg::DIGITS_LOW_W;
    localparam int O_ST   = O_DH + b36c_pkg::DIGITS_HIGH_W;
    localparam int O_END  = O_ST + b36c_pkg::STATUS_W;

    logic                 pipe_valid [0:NSTAGE];
    logic                 pipe_ready [0:NSTAGE];
    b36c_pkg::b36c_ctl_t  pipe_ctl   [0:NSTAGE];
    logic [DW-1:0]        pipe_digits[0:NSTAGE];
    logic [BIT_COUNT-1:0] pipe_bits  [0:NSTAGE];

    logic [b36c_pkg::BITS_LOW_W-1:0]    out_bits_low;
    logic [b36c_pkg::BITS_HIGH_W-1:0]   out_bits_high;
    logic [b36c_pkg::DIGITS_LOW_W-1:0]  out_digits_low;
    logic [b36c_pkg::DIGITS_HIGH_W-1:0] out_digits_high;
    b36c_pkg::b36c_status_t             status;

    b36c_front #(
        .BIT_COUNT   (BIT_COUNT),
        .DIGIT_COUNT (DIGIT_COUNT)
    ) u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .valid_i       (s_tvalid),
        .ready_o       (s_tready),
        .func_i        (s_tuser),
        .bits_low_i    (s_tdata[O_BH-1:0]),
        .bits_high_i   (s_tdata[O_DL-1:O_BH]),
        .digits_low_i  (s_tdata[O_DH-1:O_DL]),
        .digits_high_i (s_tdata[O_ST-1:O_DH]),
        .valid_o       (pipe_valid[0]),
        .ready_i       (pipe_ready[0]),
        .ctl_o         (pipe_ctl[0]),
        .digits_o      (pipe_digits[0]),
        .bits_o        (pipe_bits[0])
    );

    for (genvar g = 0; g < NSTAGE; g++) begin : g_stage
        b36c_stage #(
            .BIT_COUNT   (BIT_COUNT),
            .DIGIT_COUNT (DIGIT_COUNT),
            .START_STEP  (g * b36c_pkg::STEPS_PER_STAGE)
        ) u_stage (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .valid_i  (pipe_valid[g]),
            .ready_o  (pipe_ready[g]),
            .ctl_i    (pipe_ctl[g]),
            .digits_i (pipe_digits[g]),
            .bits_i   (pipe_bits[g]),
            .valid_o  (pipe_valid[g+1]),
            .ready_i  (pipe_ready[g+1]),
            .ctl_o    (pipe_ctl[g+1]),
            .digits_o (pipe_digits[g+1]),
            .bits_o   (pipe_bits[g+1])
        );
    end

    b36c_back #(
        .BIT_COUNT   (BIT_COUNT),
        .DIGIT_COUNT (DIGIT_COUNT)
    ) u_back (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .valid_i           (pipe_valid[NSTAGE]),
        .ready_o           (pipe_ready[NSTAGE]),
        .ctl_i             (pipe_ctl[NSTAGE]),
        .digits_i          (pipe_digits[NSTAGE]),
        .bits_i            (pipe_bits[NSTAGE]),
        .valid_o           (m_tvalid),
        .ready_i           (m_tready),
        .out_bits_low_o    (out_bits_low),
        .out_bits_high_o   (out_bits_high),
        .out_digits_low_o  (out_digits_low),
        .out_digits_high_o (out_digits_high),
        .status_o          (status)
    );

    assign m_tdata = {(176 - O_END)'(0), status, out_digits_high, out_digits_low,
                      out_bits_high, out_bits_low};

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output word valid right after reset");

    a_stall_only_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input stalled while the output is free");

    a_one_kind_of_result: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[O_DL-1:0] == '0 || m_tdata[O_ST-1:O_DL] == '0)
        else $error("result carries both bits and digits");

    a_bad_digit_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[O_END-1:O_ST] == b36c_pkg::STATUS_BAD_DIGIT
        |-> m_tdata[O_ST-1:0] == '0)
        else $error("bad digit result is not cleared");

endmodule

`default_nettype wire
